// File: sv/rgbema_pkg.sv
// rgbema_pkg: shared types and constants for the rgb segment ema smoother
// no dependencies; imported by rgbema_blend and rgb_segment_ema_smoother_top
package rgbema_pkg;

	localparam int BYTE_W    = 8;
	localparam int SEG_W     = 4;
	localparam int CHANNELS  = 3;
	localparam int WEIGHT_W  = 9;
	localparam int TDATA_W   = 32;
	localparam int TDATA_PAD = TDATA_W - SEG_W - CHANNELS * BYTE_W;

	localparam logic [WEIGHT_W-1:0] WEIGHT_MIN   = 9'd13;
	localparam logic [WEIGHT_W-1:0] WEIGHT_MAX   = 9'd256;
	localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 9'd77;

	typedef logic [CHANNELS-1:0][BYTE_W-1:0] rgb_t;

	typedef struct packed {
		logic             restart;
		logic [SEG_W-1:0] seg;
		rgb_t             rgb;
	} item_t;

	function automatic logic [WEIGHT_W-1:0] clamp_weight(input logic [WEIGHT_W-1:0] w);
		logic [WEIGHT_W-1:0] r;
		r = w;
		if (w < WEIGHT_MIN) begin
			r = WEIGHT_MIN;
		end else if (w > WEIGHT_MAX) begin
			r = WEIGHT_MAX;
		end
		return r;
	endfunction

endpackage

// File: sv/rgbema_blend.sv
// rgbema_blend: one color channel of the ema update and the byte rounding
// depends on rgbema_pkg
module rgbema_blend #(
	parameter int FRAC_BITS = 8
) (
	input  logic [rgbema_pkg::BYTE_W+FRAC_BITS-1:0] avg_old,
	input  logic [rgbema_pkg::BYTE_W-1:0]           sample,
	input  logic [rgbema_pkg::WEIGHT_W-1:0]         weight,
	input  logic                                    copy,
	output logic [rgbema_pkg::BYTE_W+FRAC_BITS-1:0] avg_new,
	output logic [rgbema_pkg::BYTE_W-1:0]           byte_out
);
	import rgbema_pkg::*;

	localparam int AW = BYTE_W + FRAC_BITS;
	localparam int PW = AW + WEIGHT_W + 2;

	logic [AW-1:0]        fresh;
	logic signed [AW:0]   diff;
	logic signed [PW-1:0] prod;
	logic signed [PW-1:0] sum;
	logic [AW:0]          rnd;

	// old + floor(a * (fresh - old) / 256)
	assign fresh = {sample, {FRAC_BITS{1'b0}}};
	assign diff  = $signed({1'b0, fresh}) - $signed({1'b0, avg_old});
	assign prod  = $signed({1'b0, weight}) * diff;
	assign sum   = $signed({{(PW-AW){1'b0}}, avg_old}) + (prod >>> 8);

	assign avg_new = copy ? fresh : sum[AW-1:0];

	// round half up, saturate to a byte
	assign rnd = {1'b0, avg_new} + ((AW+1)'(1) << (FRAC_BITS - 1));
	assign byte_out = rnd[AW] ? {BYTE_W{1'b1}} : rnd[FRAC_BITS+BYTE_W-1:FRAC_BITS];

endmodule

// File: sv/rgb_segment_ema_smoother_top.sv
// rgb_segment_ema_smoother_top: per segment rgb ema smoother, stream in and out
// depends on rgbema_pkg and rgbema_blend
//
// usage:
//   s_tdata carries one segment sample per transfer, s_tuser the restart flag.
//   m_tdata returns that segment's smoothed color (raw if seg >= SEGMENTS), one transfer per input.
//   cfg_wen/cfg_wdata write the new-sample weight in 1/256 units; the value is
//   clamped to 13..256. write only while no transfer is in flight.
// path: each input transfer is held in the input register, then passes through
//   the blend logic into the output register, which drives m_tvalid.
// throughput: one transfer per cycle unless m_tready stalls; the averages are read and
//   written back in the same cycle, so a segment may repeat on consecutive transfers.
// reset: all averages clear to zero, the weight returns to 77 and the first
//   full frame (up to the last segment) copies samples straight in.
// stall: when m_tready is low the result holds in the output register, one
//   more item waits in the input register, then s_tready drops.
module rgb_segment_ema_smoother_top #(
	parameter int SEGMENTS  = 10,
	parameter int FRAC_BITS = 8
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [rgbema_pkg::TDATA_W-1:0]   s_tdata,  // segment, red_in, green_in, blue_in
	input  logic                             s_tuser,  // restart
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [rgbema_pkg::TDATA_W-1:0]   m_tdata,  // segment_out, red_out, green_out, blue_out
	input  logic                             cfg_wen,
	input  logic [rgbema_pkg::WEIGHT_W-1:0]  cfg_wdata
);
	import rgbema_pkg::*;

	localparam int AW    = BYTE_W + FRAC_BITS;
	localparam int IDX_W = (SEGMENTS > 1) ? $clog2(SEGMENTS) : 1;

	logic [WEIGHT_W-1:0] weight_q;
	logic                primed_q;
	logic [AW-1:0]       avg_q [CHANNELS][SEGMENTS];

	item_t               item_s1;
	logic                valid_s1;
	logic                valid_s2;
	logic [SEG_W-1:0]    seg_s2;
	rgb_t                rgb_s2;

	logic                advance;
	logic                seg_ok;
	logic                seg_last;
	logic                copy;
	logic [IDX_W-1:0]    idx;
	logic [AW-1:0]       avg_old [CHANNELS];
	logic [AW-1:0]       avg_new [CHANNELS];
	rgb_t                byte_new;
	rgb_t                rgb_res;

	assign advance  = !valid_s2 || m_tready;
	assign s_tready = !valid_s1 || advance;
	assign m_tvalid = valid_s2;
	assign m_tdata  = {{TDATA_PAD{1'b0}}, rgb_s2, seg_s2};

	assign seg_ok   = {3'b000, item_s1.seg} < 7'(SEGMENTS);
	assign seg_last = {3'b000, item_s1.seg} == 7'(SEGMENTS - 1);
	assign copy     = !primed_q || item_s1.restart;
	assign idx      = IDX_W'(item_s1.seg);

	for (genvar ch = 0; ch < CHANNELS; ch++) begin : g_ch
		assign avg_old[ch] = seg_ok ? avg_q[ch][idx] : '0;

		rgbema_blend #(
			.FRAC_BITS(FRAC_BITS)
		) u_blend (
			.avg_old  (avg_old[ch]),
			.sample   (item_s1.rgb[ch]),
			.weight   (weight_q),
			.copy     (copy),
			.avg_new  (avg_new[ch]),
			.byte_out (byte_new[ch])
		);
	end

	assign rgb_res = seg_ok ? byte_new : item_s1.rgb;

	// config register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			weight_q <= WEIGHT_RESET;
		end else if (cfg_wen) begin
			weight_q <= clamp_weight(cfg_wdata);
		end
	end

	// control: pipeline valids and primed flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			primed_q <= 1'b0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (advance) begin
				valid_s2 <= valid_s1;
				if (valid_s1) begin
					primed_q <= (primed_q && !item_s1.restart) || (seg_ok && seg_last);
				end
			end
		end
	end

	// segment averages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < CHANNELS; c++) begin
				for (int s = 0; s < SEGMENTS; s++) begin
					avg_q[c][s] <= '0;
				end
			end
		end else if (advance && valid_s1 && seg_ok) begin
			for (int c = 0; c < CHANNELS; c++) begin
				avg_q[c][idx] <= avg_new[c];
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1.restart <= s_tuser;
			item_s1.seg     <= s_tdata[SEG_W-1:0];
			item_s1.rgb     <= s_tdata[SEG_W+CHANNELS*BYTE_W-1:SEG_W];
		end
		if (advance && valid_s1) begin
			seg_s2 <= item_s1.seg;
			rgb_s2 <= rgb_res;
		end
	end

endmodule

// File: tb/rgb_segment_ema_smoother_top_tb.sv
// rgb_segment_ema_smoother_top_tb: self-checking bench for the rgb segment ema smoother
// depends on rgbema_pkg and rgb_segment_ema_smoother_top; predicts each smoothed color
// per segment, runs directed samples then random frames under several handshake loads
`timescale 1ns / 1ps

module rgb_segment_ema_smoother_top_tb;
	import rgbema_pkg::*;

	localparam int NUM_SEG = 10;
	localparam int FRAC    = 8;

	class ema_color_board;
		bit [15:0]         avg_level[CHANNELS][NUM_SEG];
		bit                primed;
		bit [WEIGHT_W-1:0] weight;
		bit [TDATA_W-1:0]  smoothed_q[$];
		int                errors;

		function new();
			foreach (avg_level[c, s]) avg_level[c][s] = '0;
			primed = 1'b0;
			weight = WEIGHT_RESET;
			errors = 0;
		endfunction

		function void set_weight(bit [WEIGHT_W-1:0] w);
			if (w < WEIGHT_MIN) begin
				weight = WEIGHT_MIN;
			end else if (w > WEIGHT_MAX) begin
				weight = WEIGHT_MAX;
			end else begin
				weight = w;
			end
		endfunction

		function bit [15:0] blend_level(bit [15:0] prev, bit [7:0] sample, bit copy);
			bit [31:0] fresh;
			bit [31:0] mix;
			fresh = {16'd0, sample, 8'd0};
			if (copy) begin
				mix = fresh;
			end else begin
				mix = (weight * fresh + (32'd256 - weight) * prev) >> 8;
			end
			return mix[15:0];
		endfunction

		function bit [7:0] round_level(bit [15:0] lvl);
			bit [16:0] r;
			r = ({1'b0, lvl} + 17'd128) >> FRAC;
			return (r > 17'd255) ? 8'd255 : r[7:0];
		endfunction

		function void take_sample(bit [SEG_W-1:0] seg, bit [7:0] r, bit [7:0] g,
			bit [7:0] b, bit rs);
			bit [7:0] smp[CHANNELS];
			bit [7:0] res[CHANNELS];
			smp[0] = r;
			smp[1] = g;
			smp[2] = b;
			if (rs) primed = 1'b0;
			if (seg >= NUM_SEG) begin
				res = smp;
			end else begin
				for (int c = 0; c < CHANNELS; c++) begin
					avg_level[c][seg] = blend_level(avg_level[c][seg], smp[c], !primed);
					res[c] = round_level(avg_level[c][seg]);
				end
				if (seg == NUM_SEG - 1) primed = 1'b1;
			end
			smoothed_q.push_back({{TDATA_PAD{1'b0}}, res[2], res[1], res[0], seg});
		endfunction

		function void report(string what, int exp_v, int act_v);
			errors++;
			if (errors <= 10)
				$display("%0t mismatch %s: expected %0d actual %0d", $time, what, exp_v, act_v);
		endfunction

		function void compare_color(bit [TDATA_W-1:0] got);
			bit [TDATA_W-1:0] want;
			if (smoothed_q.size() == 0) begin
				report("unexpected transfer, segment", -1, got[SEG_W-1:0]);
				return;
			end
			want = smoothed_q.pop_front();
			if (want[3:0] != got[3:0]) report("segment_out", want[3:0], got[3:0]);
			if (want[11:4] != got[11:4]) report("red_out", want[11:4], got[11:4]);
			if (want[19:12] != got[19:12]) report("green_out", want[19:12], got[19:12]);
			if (want[27:20] != got[27:20]) report("blue_out", want[27:20], got[27:20]);
		endfunction

		function int pending();
			return smoothed_q.size();
		endfunction
	endclass

	logic                clk = 1'b0;
	logic                arst_n;
	logic                s_tvalid;
	logic                s_tready;
	logic [TDATA_W-1:0]  s_tdata;
	logic                s_tuser;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [TDATA_W-1:0]  m_tdata;
	logic                cfg_wen;
	logic [WEIGHT_W-1:0] cfg_wdata;

	int src_idle_pct   = 0;
	int sink_stall_pct = 0;
	ema_color_board board;

	rgb_segment_ema_smoother_top #(
		.SEGMENTS(NUM_SEG),
		.FRAC_BITS(FRAC)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_wen(cfg_wen),
		.cfg_wdata(cfg_wdata)
	);

	always #5 clk = ~clk;

	always @(negedge clk) begin
		m_tready <= ($urandom_range(99) >= sink_stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) board.compare_color(m_tdata);
	end

	function automatic logic [7:0] pick_byte();
		if ($urandom_range(3) == 0) return $urandom_range(1) ? 8'd255 : 8'd0;
		return 8'($urandom_range(255));
	endfunction

	task automatic send_sample(input logic [SEG_W-1:0] seg, input logic [7:0] r,
		input logic [7:0] g, input logic [7:0] b, input logic rs);
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {{TDATA_PAD{1'b0}}, b, g, r, seg};
		s_tuser  <= rs;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		board.take_sample(seg, r, g, b, rs);
		@(negedge clk);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (board.pending() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_weight(input logic [WEIGHT_W-1:0] w);
		drain();
		cfg_wen   <= 1'b1;
		cfg_wdata <= w;
		@(negedge clk);
		cfg_wen <= 1'b0;
		board.set_weight(w);
	endtask

	initial begin
		logic [WEIGHT_W-1:0] weights[8];
		int sent;
		int mode;
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = 1'b0;
		cfg_wen   = 1'b0;
		cfg_wdata = '0;
		board     = new();
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// first frame copies, then blending at the reset weight
		send_sample(0, 8'd0, 8'd0, 8'd0, 1'b0);
		send_sample(1, 8'd255, 8'd255, 8'd255, 1'b0);
		send_sample(2, 8'd255, 8'd0, 8'd128, 1'b0);
		send_sample(3, 8'd1, 8'd254, 8'd127, 1'b0);
		send_sample(4, 8'd85, 8'd170, 8'd15, 1'b0);
		send_sample(5, 8'd240, 8'd7, 8'd200, 1'b0);
		send_sample(6, 8'd0, 8'd255, 8'd0, 1'b0);
		send_sample(7, 8'd255, 8'd0, 8'd255, 1'b0);
		send_sample(8, 8'd128, 8'd128, 8'd128, 1'b0);
		send_sample(9, 8'd255, 8'd255, 8'd0, 1'b0);
		send_sample(0, 8'd255, 8'd255, 8'd255, 1'b0);
		send_sample(1, 8'd0, 8'd0, 8'd0, 1'b0);
		send_sample(1, 8'd0, 8'd0, 8'd0, 1'b0);
		send_sample(15, 8'd170, 8'd85, 8'd255, 1'b0);
		send_sample(10, 8'd1, 8'd2, 8'd3, 1'b1);
		send_sample(3, 8'd200, 8'd100, 8'd50, 1'b0);
		send_sample(9, 8'd10, 8'd20, 8'd30, 1'b0);
		send_sample(9, 8'd250, 8'd240, 8'd230, 1'b0);
		send_sample(5, 8'd255, 8'd0, 8'd255, 1'b1);
		send_sample(5, 8'd0, 8'd255, 8'd0, 1'b0);
		send_sample(12, 8'd0, 8'd0, 8'd0, 1'b1);

		weights = '{9'd0, 9'd256, 9'd511, 9'd12, 9'd13, 9'd255, 9'd1, 9'd77};
		weights[5] = WEIGHT_W'($urandom_range(511));
		for (int phase = 0; phase < 8; phase++) begin
			write_weight(weights[phase]);
			mode = phase % 4;
			src_idle_pct   = (mode == 1) ? 51 : (mode == 3) ? 7 : 0;
			sink_stall_pct = (mode == 2) ? 51 : (mode == 3) ? 7 : 0;
			sent = 0;
			while (sent < 178) begin
				if ($urandom_range(99) < 80) begin
					for (int s = 0; s < NUM_SEG; s++) begin
						send_sample(SEG_W'(s), pick_byte(), pick_byte(), pick_byte(),
							(s == 0) && ($urandom_range(9) == 0));
					end
					sent += NUM_SEG;
				end else begin
					send_sample(SEG_W'($urandom_range(15)), pick_byte(), pick_byte(),
						pick_byte(), $urandom_range(19) == 0);
					sent++;
				end
			end
		end

		drain();
		repeat (6) @(negedge clk);
		if (board.errors == 0 && board.pending() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

	initial begin
		#(5_000_000);
		$display("== FAIL ==");
		$finish;
	end

endmodule
